// ===== design/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared widths, register indexes, reset values, sequencer states and the
// status struct of the serial arithmetic units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skf_pkg;

   localparam int ANGLE_WIDTH_DEF   = 32;
   localparam int COV_FRAC_BITS_DEF = 24;
   localparam int COV_WIDTH         = 32;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROC_VAR  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEAS_VAR  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_COV = 2'd2;

   localparam logic [COV_WIDTH-1:0] PROC_VAR_RESET  = 32'd167772;
   localparam logic [COV_WIDTH-1:0] MEAS_VAR_RESET  = 32'd4194304;
   localparam logic [COV_WIDTH-1:0] START_COV_RESET = 32'd16777216;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIVL,
      ST_DIVW,
      ST_MULL,
      ST_MULW,
      ST_FIN
   } skf_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } skf_unit_stat_type;

endpackage

// ===== design/skf_ifs.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter channels
// Valid/ready item channels for requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface skf_req_if #(
   parameter int ANGLE_WIDTH = skf_pkg::ANGLE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] predicted_value;
   logic signed [ANGLE_WIDTH-1:0] measured_value;

   modport source (output valid, output predicted_value, output measured_value,
                   input ready);
   modport sink   (input valid, input predicted_value, input measured_value,
                   output ready);
endinterface

interface skf_rsp_if #(
   parameter int ANGLE_WIDTH = skf_pkg::ANGLE_WIDTH_DEF,
   parameter int GAIN_WIDTH  = skf_pkg::COV_FRAC_BITS_DEF + 1
);
   logic                              valid;
   logic                              ready;
   logic signed [ANGLE_WIDTH-1:0]     estimate;
   logic [GAIN_WIDTH-1:0]             gain;
   logic [skf_pkg::COV_WIDTH-1:0]     covariance_out;

   modport source (output valid, output estimate, output gain, output covariance_out,
                   input ready);
   modport sink   (input valid, input estimate, input gain, input covariance_out,
                   output ready);
endinterface

// ===== design/scalar_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter unit
// One-dimensional Kalman update of an angle estimate with a kept covariance.
// ----------------------------------------------------------------------------
// Each request item carries a predicted and a measured angle; one response
// item returns the corrected estimate, the gain and the updated covariance.
// An item passes through a bit-serial divider for the gain and a bit-serial
// multiplier pair for the correction; a new item is accepted the cycle after
// the previous response is loaded into the output register, even if that
// response has not yet been taken. Writing start_covariance reloads the
// covariance; write the registers only while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scalar_kalman_filter_unit #(
   parameter int ANGLE_WIDTH   = skf_pkg::ANGLE_WIDTH_DEF,
   parameter int COV_FRAC_BITS = skf_pkg::COV_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   skf_req_if.sink                               req_if,
   skf_rsp_if.source                             rsp_if,
   input  logic                                  csr_write,
   input  logic [skf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [skf_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import skf_pkg::*;

   localparam int                  GAIN_WIDTH = COV_FRAC_BITS + 1;
   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1) << COV_FRAC_BITS;

   skf_state_type            state_ff, state_in;
   logic [COV_WIDTH-1:0]     pn_ff, sn_ff, err_cov_ff;
   logic [ANGLE_WIDTH-1:0]   pred_ff;
   logic [ANGLE_WIDTH:0]     diff_ff;
   logic [COV_WIDTH-1:0]     cov_ff;
   logic [GAIN_WIDTH-1:0]    gain_ff;
   logic                     rsp_valid_ff;
   logic [ANGLE_WIDTH-1:0]   est_out_ff;
   logic [GAIN_WIDTH-1:0]    gain_out_ff;
   logic [COV_WIDTH-1:0]     cov_out_ff;

   logic                     req_ready;
   logic                     req_fire;
   logic                     div_load;
   logic                     mul_load;
   logic                     out_free;
   logic                     out_load;
   logic [COV_WIDTH:0]       cov_sum;
   logic [COV_WIDTH:0]       den;
   logic [GAIN_WIDTH-1:0]    div_quo;
   logic [ANGLE_WIDTH+2:0]   mul_scaled;
   logic [COV_WIDTH-1:0]     mul_cov;
   logic [ANGLE_WIDTH+2:0]   est_sum;
   skf_unit_stat_type        div_stat;
   skf_unit_stat_type        mul_stat;

   assign req_fire = req_if.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign cov_sum  = {1'b0, err_cov_ff} + {1'b0, pn_ff};
   assign den      = {1'b0, cov_ff} + {1'b0, sn_ff};
   assign est_sum  = {{3{pred_ff[ANGLE_WIDTH-1]}}, pred_ff} + mul_scaled;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_load  = 1'b0;
      mul_load  = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_DIVL;
         end
         ST_DIVL: begin
            div_load = 1'b1;
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_stat.done) begin
               state_in = ST_MULL;
            end
         end
         ST_MULL: begin
            mul_load = 1'b1;
            state_in = ST_MULW;
         end
         ST_MULW: begin
            if (mul_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration and kept covariance
   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff      <= PROC_VAR_RESET;
         sn_ff      <= MEAS_VAR_RESET;
         err_cov_ff <= START_COV_RESET;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_PROC_VAR:  pn_ff <= csr_data[COV_WIDTH-1:0];
               CSR_MEAS_VAR:  sn_ff <= csr_data[COV_WIDTH-1:0];
               CSR_START_COV: err_cov_ff <= csr_data[COV_WIDTH-1:0];
               default: ;
            endcase
         end
         if (out_load) begin
            err_cov_ff <= mul_cov;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pred_ff <= req_if.predicted_value;
         diff_ff <= {req_if.measured_value[ANGLE_WIDTH-1], req_if.measured_value}
                  - {req_if.predicted_value[ANGLE_WIDTH-1], req_if.predicted_value};
      end
      if (state_ff == ST_SUM) begin
         cov_ff <= cov_sum[COV_WIDTH] ? '1 : cov_sum[COV_WIDTH-1:0];
      end
      if (div_stat.done) begin
         gain_ff <= div_quo;
      end
      if (out_load) begin
         est_out_ff  <= est_sum[ANGLE_WIDTH-1:0];
         gain_out_ff <= gain_ff;
         cov_out_ff  <= mul_cov;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   skf_divider #(
      .FRAC_BITS (COV_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .cov      (cov_ff),
      .den      (den),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   skf_multiplier #(
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .FRAC_BITS   (COV_FRAC_BITS)
   ) u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .load    (mul_load),
      .diff    (diff_ff),
      .cov     (cov_ff),
      .gain    (gain_ff),
      .scaled  (mul_scaled),
      .cov_new (mul_cov),
      .stat    (mul_stat)
   );

   assign req_if.ready          = req_ready;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.estimate       = est_out_ff;
   assign rsp_if.gain           = gain_out_ff;
   assign rsp_if.covariance_out = cov_out_ff;

`ifndef ASSERT_OFF
   a_div_in_divw: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy || div_stat.done |-> state_ff == ST_DIVW)
      else $error("divider active outside its wait state");
   a_mul_in_mulw: assert property (@(posedge clock) disable iff (reset)
      mul_stat.busy || mul_stat.done |-> state_ff == ST_MULW)
      else $error("multiplier active outside its wait state");
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> gain_out_ff <= GAIN_ONE)
      else $error("gain above one");
`endif

endmodule

// ===== design/skf_divider.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter gain divider
// Bit-serial restoring divider: gain = (cov << FRAC_BITS) / den, one quotient
// bit per cycle, MSB first. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skf_divider #(
   parameter int FRAC_BITS = skf_pkg::COV_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [skf_pkg::COV_WIDTH-1:0]  cov,
   input  logic [skf_pkg::COV_WIDTH:0]    den,
   output logic [FRAC_BITS:0]             quotient,
   output skf_pkg::skf_unit_stat_type     stat
);
   import skf_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 2);

   logic [COV_WIDTH:0]   rem_ff, rem_in;
   logic [COV_WIDTH:0]   den_ff, den_in;
   logic [FRAC_BITS:0]   quo_ff, quo_in;
   logic                 bit_ff, bit_in;
   logic                 zero_ff, zero_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [COV_WIDTH+1:0] trial;
   logic [COV_WIDTH+1:0] trial_sub;
   logic                 take_sub;

   assign trial     = {rem_ff, bit_ff};
   assign take_sub  = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (load) begin
         rem_in  = {2'b00, cov[COV_WIDTH-1:1]};
         bit_in  = cov[0];
         den_in  = den;
         zero_in = (den == '0);
         quo_in  = '0;
         cnt_in  = CNT_W'(FRAC_BITS + 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (take_sub) begin
            rem_in = trial_sub[COV_WIDTH:0];
         end else begin
            rem_in = trial[COV_WIDTH:0];
         end
         bit_in = 1'b0;
         quo_in = {quo_ff[FRAC_BITS-1:0], take_sub & ~zero_ff};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      bit_ff  <= bit_in;
      zero_ff <= zero_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

`ifndef ASSERT_OFF
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !zero_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && !done_ff)
      else $error("divider did not start on load");
`endif

endmodule

// ===== design/skf_multiplier.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter correction multiplier
// Two bit-serial shift-add multipliers stepped together over the gain bits:
// floor(diff * gain / 2^FRAC_BITS) and floor((1 - gain) * cov / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skf_multiplier #(
   parameter int ANGLE_WIDTH = skf_pkg::ANGLE_WIDTH_DEF,
   parameter int FRAC_BITS   = skf_pkg::COV_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [ANGLE_WIDTH:0]           diff,
   input  logic [skf_pkg::COV_WIDTH-1:0]  cov,
   input  logic [FRAC_BITS:0]             gain,
   output logic [ANGLE_WIDTH+2:0]         scaled,
   output logic [skf_pkg::COV_WIDTH-1:0]  cov_new,
   output skf_pkg::skf_unit_stat_type     stat
);
   import skf_pkg::*;

   localparam int                 CNT_W    = $clog2(FRAC_BITS + 2);
   localparam logic [FRAC_BITS:0] GAIN_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic [ANGLE_WIDTH:0]   dval_ff, dval_in;
   logic [COV_WIDTH-1:0]   cval_ff, cval_in;
   logic [FRAC_BITS:0]     gsh_ff, gsh_in;
   logic [FRAC_BITS:0]     hsh_ff, hsh_in;
   logic [ANGLE_WIDTH+1:0] acc_d_ff, acc_d_in;
   logic [COV_WIDTH-1:0]   acc_c_ff, acc_c_in;
   logic                   lsb_d_ff, lsb_d_in;
   logic                   lsb_c_ff, lsb_c_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [ANGLE_WIDTH+1:0] sum_d;
   logic [COV_WIDTH:0]     sum_c;

   assign sum_d = acc_d_ff + (gsh_ff[0] ? {dval_ff[ANGLE_WIDTH], dval_ff} : '0);
   assign sum_c = {1'b0, acc_c_ff} + (hsh_ff[0] ? {1'b0, cval_ff} : '0);

   always_comb begin
      dval_in  = dval_ff;
      cval_in  = cval_ff;
      gsh_in   = gsh_ff;
      hsh_in   = hsh_ff;
      acc_d_in = acc_d_ff;
      acc_c_in = acc_c_ff;
      lsb_d_in = lsb_d_ff;
      lsb_c_in = lsb_c_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (load) begin
         dval_in  = diff;
         cval_in  = cov;
         gsh_in   = gain;
         hsh_in   = GAIN_ONE - gain;
         acc_d_in = '0;
         acc_c_in = '0;
         lsb_d_in = 1'b0;
         lsb_c_in = 1'b0;
         cnt_in   = CNT_W'(FRAC_BITS + 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_d_in = {sum_d[ANGLE_WIDTH+1], sum_d[ANGLE_WIDTH+1:1]};
         lsb_d_in = sum_d[0];
         acc_c_in = sum_c[COV_WIDTH:1];
         lsb_c_in = sum_c[0];
         gsh_in   = {1'b0, gsh_ff[FRAC_BITS:1]};
         hsh_in   = {1'b0, hsh_ff[FRAC_BITS:1]};
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dval_ff  <= dval_in;
      cval_ff  <= cval_in;
      gsh_ff   <= gsh_in;
      hsh_ff   <= hsh_in;
      acc_d_ff <= acc_d_in;
      acc_c_ff <= acc_c_in;
      lsb_d_ff <= lsb_d_in;
      lsb_c_ff <= lsb_c_in;
   end

   // product >> FRAC_BITS = acc * 2 + last bit shifted out
   assign scaled    = {acc_d_ff, lsb_d_ff};
   assign cov_new   = {acc_c_ff[COV_WIDTH-2:0], lsb_c_ff};
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

`ifndef ASSERT_OFF
   a_cov_acc_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> acc_c_ff <= cval_ff)
      else $error("covariance accumulator exceeds covariance");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter unit testbench
// Sends angle pairs through the request channel and checks every response
// item against a bit-exact update model that tracks the covariance on the
// testbench side. Covers the angle extremes, covariance saturation, zero
// denominator, ignored register index, random register settings, random
// idling on both channels and a long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import skf_pkg::*;

   localparam int                              FRAC           = COV_FRAC_BITS_DEF;
   localparam logic [63:0]                     COV_ONE        = 64'd1 << FRAC;
   localparam logic [63:0]                     COV_SAT        = 64'hFFFF_FFFF;
   localparam logic [CSR_INDEX_WIDTH-1:0]      CSR_UNUSED     = 2'd3;
   localparam logic signed [ANGLE_WIDTH_DEF-1:0] ANGLE_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [ANGLE_WIDTH_DEF-1:0] ANGLE_MIN    = 32'sh8000_0000;
   localparam int                              WATCHDOG_LIMIT = 4000;
   localparam int                              DRAIN_CYCLES   = 80;

   typedef struct packed {
      logic signed [ANGLE_WIDTH_DEF-1:0] estimate;
      logic [COV_FRAC_BITS_DEF:0]        gain;
      logic [COV_WIDTH-1:0]              covariance;
   } filter_update_type;

   logic clock;
   logic reset;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   skf_req_if req_ch ();
   skf_rsp_if rsp_ch ();

   scalar_kalman_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // model state
   logic [COV_WIDTH-1:0] proc_var;
   logic [COV_WIDTH-1:0] meas_var;
   logic [COV_WIDTH-1:0] tracked_cov;

   filter_update_type pending_updates[$];
   int             error_count = 0;
   int             idle_cycles = 0;
   bit             tx_steady = 1'b0;
   bit             rx_steady = 1'b0;
   int unsigned    rx_hold_request = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic filter_update_type kalman_update(input logic signed [31:0] pred,
                                                       input logic signed [31:0] meas);
      logic [63:0]       cov;
      logic [63:0]       den;
      logic [63:0]       g;
      longint            diff;
      longint            prod;
      longint            est;
      filter_update_type upd;
      cov = 64'(tracked_cov) + 64'(proc_var);
      if (cov > COV_SAT) begin
         cov = COV_SAT;
      end
      den = cov + 64'(meas_var);
      g = (den != 0) ? (cov << FRAC) / den : 64'd0;
      if (g > COV_ONE) begin
         g = COV_ONE;
      end
      diff = longint'(meas) - longint'(pred);
      prod = diff * longint'(g);
      est = longint'(pred) + (prod >>> FRAC);
      cov = ((COV_ONE - g) * cov) >> FRAC;
      tracked_cov = cov[31:0];
      upd.estimate = est[31:0];
      upd.gain = g[FRAC:0];
      upd.covariance = tracked_cov;
      return upd;
   endfunction

   function automatic int unsigned pick_gap(input bit steady);
      int unsigned roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(1, 4);
      end
      if (roll < 96) begin
         return $urandom_range(5, 30);
      end
      return $urandom_range(31, 150);
   endfunction

   function automatic logic [31:0] pick_noise();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h0400_0000);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_extreme();
      return ($urandom_range(0, 1) != 0) ? ANGLE_MAX : ANGLE_MIN;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_PROC_VAR: proc_var = value;
         CSR_MEAS_VAR: meas_var = value;
         CSR_START_COV: tracked_cov = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_reading(input logic signed [31:0] pred, input logic signed [31:0] meas);
      int unsigned gap;
      gap = pick_gap(tx_steady);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.predicted_value <= pred;
      req_ch.measured_value <= meas;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      pending_updates.push_back(kalman_update(pred, meas));
   endtask

   // lower valid and let every outstanding item come back
   task automatic end_burst();
      req_ch.valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_defaults();
      write_reg(CSR_PROC_VAR, PROC_VAR_RESET);
      write_reg(CSR_MEAS_VAR, MEAS_VAR_RESET);
      write_reg(CSR_START_COV, START_COV_RESET);
   endtask

   task automatic test_extreme_angles();
      send_reading(32'sd0, 32'sd0);
      send_reading(ANGLE_MAX, ANGLE_MIN);
      send_reading(ANGLE_MIN, ANGLE_MAX);
      send_reading(ANGLE_MAX, ANGLE_MAX);
      send_reading(ANGLE_MIN, ANGLE_MIN);
      send_reading(32'sd0, -32'sd1);
      send_reading(-32'sd1, 32'sd0);
      send_reading(32'sd1, -32'sd1);
      end_burst();
   endtask

   task automatic test_covariance_saturation();
      write_reg(CSR_PROC_VAR, 32'hFFFF_FFFF);
      write_reg(CSR_START_COV, 32'hFFFF_FFFF);
      send_reading(ANGLE_MAX, ANGLE_MIN);
      send_reading(ANGLE_MIN, ANGLE_MAX);
      end_burst();
      write_reg(CSR_MEAS_VAR, 32'hFFFF_FFFF);
      send_reading(ANGLE_MIN, ANGLE_MAX);
      end_burst();
      write_reg(CSR_MEAS_VAR, 32'd0);
      send_reading(32'sh1234_5678, -32'sh0765_4321);
      end_burst();
   endtask

   task automatic test_zero_denominator();
      write_reg(CSR_PROC_VAR, 32'd0);
      write_reg(CSR_MEAS_VAR, 32'd0);
      write_reg(CSR_START_COV, 32'd0);
      send_reading(ANGLE_MIN, ANGLE_MAX);
      send_reading(ANGLE_MAX, ANGLE_MIN);
      send_reading($urandom, $urandom);
      end_burst();
      // full gain once, then the covariance collapses to zero
      write_reg(CSR_START_COV, 32'd1);
      send_reading(-32'sd5, 32'sd9);
      send_reading(32'sd9, -32'sd5);
      end_burst();
   endtask

   task automatic test_ignored_register();
      load_defaults();
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      send_reading(32'sh0001_0000, 32'sh0003_0000);
      end_burst();
      write_reg(CSR_UNUSED, 32'd0);
      send_reading(-32'sh0001_0000, 32'sh0002_8000);
      end_burst();
   endtask

   task automatic send_random_items(input int count);
      logic signed [31:0] pred;
      logic signed [31:0] meas;
      int unsigned        roll;
      int                 offset;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 9);
         pred = $urandom;
         offset = int'($urandom_range(0, 2000)) - 1000;
         if (roll < 5) begin
            meas = $urandom;
         end else if (roll < 8) begin
            meas = pred + offset;
         end else if (roll == 8) begin
            pred = pick_extreme();
            meas = pick_extreme();
         end else begin
            meas = pred;
         end
         send_reading(pred, meas);
      end
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      logic [CSR_INDEX_WIDTH-1:0] csr_order[3];
      int unsigned                first;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      csr_order = '{CSR_PROC_VAR, CSR_MEAS_VAR, CSR_START_COV};
      for (int p = 0; p < phases; p++) begin
         end_burst();
         tx_steady = (p % 4 == 0) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
         rx_steady = (p % 4 == 0) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
         first = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            idx = csr_order[(first + i) % 3];
            if (p == 0) begin
               write_reg(idx, 32'hFFFF_FFFF);
            end else if (p == 1) begin
               write_reg(idx, 32'd0);
            end else if (idx != CSR_START_COV || $urandom_range(0, 3) != 0) begin
               write_reg(idx, pick_noise());
            end
         end
         send_random_items(per_phase);
      end
      end_burst();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   task automatic test_backpressure();
      load_defaults();
      tx_steady = 1'b1;
      rx_hold_request = 400;
      send_random_items(8);
      // sender waits for all outstanding results, then goes on
      end_burst();
      send_random_items(4);
      end_burst();
      tx_steady = 1'b0;
   endtask

   initial begin : response_drain
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_request != 0) begin
            stall = rx_hold_request;
            rx_hold_request = 0;
         end else begin
            stall = pick_gap(rx_steady);
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   always @(posedge clock) begin : response_check
      filter_update_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected item est=%h gain=%h cov=%h", $time,
                     rsp_ch.estimate, rsp_ch.gain, rsp_ch.covariance_out);
            error_count++;
         end else begin
            want = pending_updates.pop_front();
            if (rsp_ch.estimate !== want.estimate) begin
               $display("%0t: estimate expected %h actual %h", $time,
                        want.estimate, rsp_ch.estimate);
               error_count++;
            end
            if (rsp_ch.gain !== want.gain) begin
               $display("%0t: gain expected %h actual %h", $time, want.gain, rsp_ch.gain);
               error_count++;
            end
            if (rsp_ch.covariance_out !== want.covariance) begin
               $display("%0t: covariance expected %h actual %h", $time,
                        want.covariance, rsp_ch.covariance_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.predicted_value <= '0;
      req_ch.measured_value <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_PROC_VAR;
      csr_data <= '0;
      proc_var = PROC_VAR_RESET;
      meas_var = MEAS_VAR_RESET;
      tracked_cov = START_COV_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_angles();
      test_covariance_saturation();
      test_zero_denominator();
      test_ignored_register();
      test_backpressure();
      test_random_phases(12, 155);

      end_burst();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
